// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the gradient filter front end.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define EG_ASSERT(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");

// Antecedent in one cycle implies the consequent in the next cycle.
`define EG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/eg5x5_pkg.sv =====
// ---------------------------------------------------------------------------
// eg5x5_pkg
// Shared types, field widths and mask taps of the 5x5 gradient filter.
// ---------------------------------------------------------------------------
package eg5x5_pkg;

    // Default sizing of the line store, row counter and queue.
    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int MAX_HEIGHT_DEF  = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Field widths.
    localparam int PIX_W      = 8;
    localparam int WIN_N      = 5;
    localparam int COLUMN_W   = PIX_W * WIN_N;
    localparam int STORE_W    = PIX_W * (WIN_N - 1);
    localparam int GRAD_W     = 15;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = OUT_DATA_W - 2 * GRAD_W - ROW_W - COL_W;
    localparam int IN_DATA_W  = 8;

    // Configuration registers.
    localparam int LW_W       = 12;
    localparam int FH_W       = 13;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 13;
    localparam int LW_RESET   = 640;
    localparam int FH_RESET   = 480;
    localparam int LW_MIN     = 8;
    localparam int FH_MIN     = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_LINE_WIDTH   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // X mask, [row][col], row 0 the oldest row. The Y mask is its transpose.
    localparam int TAP_X [WIN_N][WIN_N] = '{
        '{  0,  -6, 0,  6,  0 },
        '{-12, -20, 0, 20, 12 },
        '{-22, -20, 0, 20, 22 },
        '{-12, -20, 0, 20, 12 },
        '{  0,  -6, 0,  6,  0 }
    };

    // One classified pixel, handed from the front end to the back end.
    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic                emit;
        logic                frame_done;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
    } eg5x5_item_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } eg5x5_qstat_t;

endpackage

// ===== src/eg5x5_front.sv =====
// ---------------------------------------------------------------------------
// eg5x5_front
// Accepts pixels, tracks the raster position, classifies border and interior
// pixels and builds the five-pixel column from the line store.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module eg5x5_front #(
    parameter int MAX_WIDTH  = eg5x5_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = eg5x5_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [eg5x5_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [eg5x5_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [eg5x5_pkg::PIX_W-1:0]         s_pixel,
    input  logic                                s_sof,
    input  eg5x5_pkg::eg5x5_qstat_t             qstat,
    output logic                                push,
    output eg5x5_pkg::eg5x5_item_t              push_item
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int WW     = (eg5x5_pkg::LW_W > CW + 1) ? eg5x5_pkg::LW_W : CW + 1;
    localparam int HW     = (eg5x5_pkg::FH_W > RW + 1) ? eg5x5_pkg::FH_W : RW + 1;
    localparam int LW_RST = (eg5x5_pkg::LW_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                               : eg5x5_pkg::LW_RESET;
    localparam int FH_RST = (eg5x5_pkg::FH_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : eg5x5_pkg::FH_RESET;
    localparam int PW     = eg5x5_pkg::PIX_W;
    localparam int SW     = eg5x5_pkg::STORE_W;

    // Configuration, held clamped to the supported range.
    logic [WW-1:0] eff_w_reg;
    logic [HW-1:0] eff_h_reg;
    logic [WW-1:0] lw_in;
    logic [HW-1:0] fh_in;
    logic [WW-1:0] lw_clamped;
    logic [HW-1:0] fh_clamped;

    // Position of the next pixel.
    logic [CW-1:0] col_cnt_reg;
    logic [RW-1:0] row_cnt_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    logic [CW-1:0] c_eff;
    logic [RW-1:0] r_eff;
    logic [WW-1:0] c_ext;
    logic [HW-1:0] r_ext;
    logic [WW-1:0] c_inc;
    logic [HW-1:0] r_inc;
    logic          emit_next;
    logic          done_next;

    // Stage holding the accepted pixel while the line store read returns.
    logic                         f1_valid_reg;
    logic [PW-1:0]                f1_pixel_reg;
    logic [CW-1:0]                f1_slot_reg;
    logic                         f1_emit_reg;
    logic                         f1_done_reg;
    logic [eg5x5_pkg::ROW_W-1:0]  f1_row_reg;
    logic [eg5x5_pkg::COL_W-1:0]  f1_col_reg;
    logic                         f1_byp_reg;
    logic [SW-1:0]                f1_bypd_reg;
    logic [SW-1:0]                ram_q_reg;
    logic [SW-1:0]                store_word;
    logic [eg5x5_pkg::COLUMN_W-1:0] f1_column;
    logic                         accept;
    logic                         f1_go;

    // Line store: per column the four previous rows, newest in the low byte.
    logic [SW-1:0] mem [MAX_WIDTH];

    // Clamp incoming register values.
    assign lw_in = WW'(cfg_wdata[eg5x5_pkg::LW_W-1:0]);
    assign fh_in = HW'(cfg_wdata[eg5x5_pkg::FH_W-1:0]);
    assign lw_clamped = (lw_in < WW'(eg5x5_pkg::LW_MIN)) ? WW'(eg5x5_pkg::LW_MIN) :
                        (lw_in > WW'(MAX_WIDTH))         ? WW'(MAX_WIDTH) : lw_in;
    assign fh_clamped = (fh_in < HW'(eg5x5_pkg::FH_MIN)) ? HW'(eg5x5_pkg::FH_MIN) :
                        (fh_in > HW'(MAX_HEIGHT))        ? HW'(MAX_HEIGHT) : fh_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg <= WW'(LW_RST);
            eff_h_reg <= HW'(FH_RST);
        end else if (cfg_we) begin
            case (cfg_addr)
                eg5x5_pkg::REG_LINE_WIDTH:   eff_w_reg <= lw_clamped;
                eg5x5_pkg::REG_FRAME_HEIGHT: eff_h_reg <= fh_clamped;
                default: ;
            endcase
        end
    end

    // Handshake: the stage frees up whenever its pixel moves into the queue.
    assign f1_go   = f1_valid_reg && !qstat.full;
    assign s_ready = !f1_valid_reg || !qstat.full;
    assign accept  = s_valid && s_ready;
    assign push    = f1_go;

    // Position of this pixel, classification and next position.
    always_comb begin
        c_eff = s_sof ? '0 : col_cnt_reg;
        r_eff = s_sof ? '0 : row_cnt_reg;
        c_ext = WW'(c_eff);
        r_ext = HW'(r_eff);
        c_inc = c_ext + WW'(1);
        r_inc = r_ext + HW'(1);
        emit_next = (r_ext >= HW'(4)) && (c_ext >= WW'(4)) &&
                    (r_ext < eff_h_reg) && (c_ext < eff_w_reg);
        done_next = (r_ext == eff_h_reg - HW'(1)) && (c_ext == eff_w_reg - WW'(1));
        if (c_inc >= eff_w_reg) begin
            col_next = '0;
            row_next = (r_inc >= eff_h_reg) ? '0 : r_inc[RW-1:0];
        end else begin
            col_next = c_inc[CW-1:0];
            row_next = r_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (accept) begin
            col_cnt_reg <= col_next;
            row_cnt_reg <= row_next;
        end
    end

    // Column assembly; forward the word written in the cycle of the read.
    assign store_word = f1_byp_reg ? f1_bypd_reg : ram_q_reg;
    assign f1_column  = {store_word, f1_pixel_reg};

    always_ff @(posedge aclk) begin
        if (accept) begin
            ram_q_reg <= mem[c_eff];
        end
        if (f1_go) begin
            mem[f1_slot_reg] <= f1_column[SW-1:0];
        end
    end

    // Pixel stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f1_byp_reg   <= 1'b0;
        end else if (accept) begin
            f1_valid_reg <= 1'b1;
            f1_byp_reg   <= f1_go && (f1_slot_reg == c_eff);
        end else if (f1_go) begin
            f1_valid_reg <= 1'b0;
            f1_byp_reg   <= 1'b0;
        end
        if (accept) begin
            f1_pixel_reg <= s_pixel;
            f1_slot_reg  <= c_eff;
            f1_emit_reg  <= emit_next;
            f1_done_reg  <= done_next;
            f1_row_reg   <= eg5x5_pkg::ROW_W'(r_ext - HW'(2));
            f1_col_reg   <= eg5x5_pkg::COL_W'(c_ext - WW'(2));
            f1_bypd_reg  <= f1_column[SW-1:0];
        end
    end

    // Item toward the queue.
    always_comb begin
        push_item.column     = f1_column;
        push_item.emit       = f1_emit_reg;
        push_item.frame_done = f1_done_reg;
        push_item.row        = f1_row_reg;
        push_item.col        = f1_col_reg;
    end

    // A held pixel keeps its slot until it moves on.
    `EG_ASSERT_NEXT(a_hold_slot, aclk, aresetn, f1_valid_reg && qstat.full, f1_valid_reg && $stable(f1_slot_reg))
    // Forwarding is only armed for a pixel that is present.
    `EG_ASSERT(a_byp_valid, aclk, aresetn, !f1_byp_reg || f1_valid_reg)
    // Every accepted pixel occupies the stage in the next cycle.
    `EG_ASSERT_NEXT(a_accept_fill, aclk, aresetn, accept, f1_valid_reg)

endmodule

// ===== src/eg5x5_fifo.sv =====
// ---------------------------------------------------------------------------
// eg5x5_fifo
// Short queue of classified pixels between the front and back ends.
// ---------------------------------------------------------------------------
module eg5x5_fifo #(
    parameter int DEPTH = eg5x5_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  eg5x5_pkg::eg5x5_item_t   push_item,
    input  logic                     pop,
    output eg5x5_pkg::eg5x5_item_t   pop_item,
    output eg5x5_pkg::eg5x5_qstat_t  qstat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    eg5x5_pkg::eg5x5_item_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign qstat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_item    = slots_reg[rd_ptr_reg];

    // Storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + CNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - CNT_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== src/eg5x5_back.sv =====
// ---------------------------------------------------------------------------
// eg5x5_back
// Shifts columns into the 5x5 window, sums the X and Y masks in two
// registered steps and holds the result for the output transfer.
// ---------------------------------------------------------------------------
module eg5x5_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  eg5x5_pkg::eg5x5_qstat_t              qstat,
    input  eg5x5_pkg::eg5x5_item_t               pop_item,
    output logic                                 pop,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [eg5x5_pkg::OUT_DATA_W-1:0]     m_data,
    output logic                                 m_last
);

    localparam int N     = eg5x5_pkg::WIN_N;
    localparam int PW    = eg5x5_pkg::PIX_W;
    localparam int RS_W  = 16;
    localparam int SUM_W = 17;
    localparam int GW    = eg5x5_pkg::GRAD_W;

    logic en;

    // Window, column 0 the oldest, byte 0 of a column the newest row.
    logic [eg5x5_pkg::COLUMN_W-1:0] win_reg [N];
    logic                           b1_valid_reg;
    logic                           b1_done_reg;
    logic [eg5x5_pkg::ROW_W-1:0]    b1_row_reg;
    logic [eg5x5_pkg::COL_W-1:0]    b1_col_reg;

    // Per-row partial sums.
    logic signed [RS_W-1:0]         px_s [N][N];
    logic signed [RS_W-1:0]         rx_next [N];
    logic signed [RS_W-1:0]         ry_next [N];
    logic signed [RS_W-1:0]         rx_reg [N];
    logic signed [RS_W-1:0]         ry_reg [N];
    logic                           b2_valid_reg;
    logic                           b2_done_reg;
    logic [eg5x5_pkg::ROW_W-1:0]    b2_row_reg;
    logic [eg5x5_pkg::COL_W-1:0]    b2_col_reg;

    // Final sums and halving.
    logic signed [SUM_W-1:0]        sum_x;
    logic signed [SUM_W-1:0]        sum_y;
    logic signed [SUM_W-1:0]        adj_x;
    logic signed [SUM_W-1:0]        adj_y;
    logic signed [SUM_W-1:0]        half_x;
    logic signed [SUM_W-1:0]        half_y;

    logic                           m_valid_reg;
    logic                           m_last_reg;
    logic [eg5x5_pkg::OUT_DATA_W-1:0] m_data_reg;

    // The whole back end advances together when the output slot frees up.
    assign en  = !m_valid_reg || m_ready;
    assign pop = en && !qstat.empty;

    // Window shift and first stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < N; j++) begin
                win_reg[j] <= '0;
            end
            b1_valid_reg <= 1'b0;
        end else if (en) begin
            if (pop) begin
                for (int j = 0; j < N - 1; j++) begin
                    win_reg[j] <= win_reg[j + 1];
                end
                win_reg[N - 1] <= pop_item.column;
            end
            b1_valid_reg <= pop && pop_item.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_done_reg <= pop_item.frame_done;
            b1_row_reg  <= pop_item.row;
            b1_col_reg  <= pop_item.col;
        end
    end

    // Row sums of both masks over the current window.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                px_s[i][j] = $signed(RS_W'(win_reg[j][PW * (N - 1 - i) +: PW]));
            end
        end
        for (int i = 0; i < N; i++) begin
            rx_next[i] = '0;
            ry_next[i] = '0;
            for (int j = 0; j < N; j++) begin
                rx_next[i] = rx_next[i] + px_s[i][j] * RS_W'(eg5x5_pkg::TAP_X[i][j]);
                ry_next[i] = ry_next[i] + px_s[i][j] * RS_W'(eg5x5_pkg::TAP_X[j][i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg <= 1'b0;
        end else if (en) begin
            b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N; i++) begin
                rx_reg[i] <= rx_next[i];
                ry_reg[i] <= ry_next[i];
            end
            b2_done_reg <= b1_done_reg;
            b2_row_reg  <= b1_row_reg;
            b2_col_reg  <= b1_col_reg;
        end
    end

    // Total of the rows, halved toward zero.
    always_comb begin
        sum_x = '0;
        sum_y = '0;
        for (int i = 0; i < N; i++) begin
            sum_x = sum_x + SUM_W'(rx_reg[i]);
            sum_y = sum_y + SUM_W'(ry_reg[i]);
        end
        adj_x  = sum_x + $signed(SUM_W'(sum_x[SUM_W-1]));
        adj_y  = sum_y + $signed(SUM_W'(sum_y[SUM_W-1]));
        half_x = adj_x >>> 1;
        half_y = adj_y >>> 1;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_last_reg <= b2_done_reg;
            m_data_reg <= {{eg5x5_pkg::OUT_PAD_W{1'b0}}, b2_col_reg, b2_row_reg,
                           half_y[GW-1:0], half_x[GW-1:0]};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_last  = m_last_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/edge_gradient_5x5.sv =====
// ---------------------------------------------------------------------------
// edge_gradient_5x5
// Streaming 5x5 gradient filter: X and Y mask sums, halved, for every
// interior pixel of a raster-ordered 8-bit grayscale frame.
// ---------------------------------------------------------------------------
//  Channel   Ports                 Contents (lowest bit first)
//  input     s_tvalid/s_tready     tdata: pixel[7:0]; tuser: start_of_frame
//  result    m_tvalid/m_tready     tdata: grad_x, grad_y, center_row,
//                                  center_col, zero pad; tlast: frame_done
//  config    cfg_we/cfg_addr       0 line_width, 1 frame_height
//
//  One pixel per clock sustained while the result side keeps up; the dual-port line store takes one read at
//  acceptance and, on its other port, one write when the pixel enters the queue.
//  With the queue empty and no stall, the pixel that completes the result moves
//  through the pixel stage, queue, window, row sums and output register to m_tvalid.
//  Reset is synchronous and active low; the line store needs no clearing.
//  Result back-pressure stalls the window and adder stages together; the
//  queue lets the input keep going for a few pixels before it stalls too.
// ---------------------------------------------------------------------------
module edge_gradient_5x5 #(
    parameter int MAX_WIDTH   = eg5x5_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = eg5x5_pkg::MAX_HEIGHT_DEF,
    parameter int QUEUE_DEPTH = eg5x5_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration writes.
    input  logic                                cfg_we,
    input  logic [eg5x5_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [eg5x5_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Pixel input.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [eg5x5_pkg::IN_DATA_W-1:0]     s_tdata,   // pixel
    input  logic                                s_tuser,   // start_of_frame
    // Gradient output.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [eg5x5_pkg::OUT_DATA_W-1:0]    m_tdata,   // grad_x, grad_y, row, col
    output logic                                m_tlast    // frame_done
);

    eg5x5_pkg::eg5x5_qstat_t qstat;
    eg5x5_pkg::eg5x5_item_t  push_item;
    eg5x5_pkg::eg5x5_item_t  pop_item;
    logic                    push;
    logic                    pop;

    // Front end: position tracking, classification, line store.
    eg5x5_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_pixel   (s_tdata[eg5x5_pkg::PIX_W-1:0]),
        .s_sof     (s_tuser),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    // Queue between the two ends.
    eg5x5_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .qstat     (qstat)
    );

    // Back end: window, mask sums, output register.
    eg5x5_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qstat    (qstat),
        .pop_item (pop_item),
        .pop      (pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_tdata),
        .m_last   (m_tlast)
    );

endmodule
